// ===== hw/rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int CfgW = 5;

  typedef struct packed {
    logic step;
    logic restart;
    logic flush;
  } swm_ctrl_t;

endpackage

// ===== hw/rtl/swm_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_window
// Sorted window cells with arrival ages: retire the oldest cell of a full window
// and insert the new sample in one pass, presenting the updated cell values.
// ----------------------------------------------------------------------------
module swm_window #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swm_pkg::swm_ctrl_t            ctrl_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] k_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] vals_o [MAX_WINDOW],
  output logic                          emit_o
);
  import swm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic signed [SAMPLE_BITS-1:0] val_q [MAX_WINDOW];
  logic [IW-1:0]                 age_q [MAX_WINDOW];
  logic [IW-1:0]                 age_d [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] cv    [MAX_WINDOW];
  logic [IW-1:0]                 ca    [MAX_WINDOW];
  logic [CW-1:0]                 fill_q, fill_d;
  logic [CW-1:0]                 fill_eff, kdec, pos;
  logic [IW-1:0]                 k_m1;
  logic [MAX_WINDOW-1:0]         valid, rem, le, gone;
  logic                          full;

  always_comb begin
    logic acc;
    int   nxt;
    int   prv;
    fill_eff = ctrl_i.restart ? '0 : fill_q;
    full     = (fill_eff == k_i);
    kdec     = k_i - CW'(1);
    k_m1     = kdec[IW-1:0];
    acc      = 1'b0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      valid[j] = (CW'(j) < fill_eff);
      rem[j]   = full && valid[j] && (age_q[j] == k_m1);
      le[j]    = valid[j] && !rem[j] && (val_q[j] <= sample_i);
      acc      = acc | rem[j];
      gone[j]  = acc;
    end
    for (int j = 0; j < MAX_WINDOW; j++) begin
      nxt = (j < MAX_WINDOW - 1) ? j + 1 : j;
      if (gone[j]) begin
        cv[j] = val_q[nxt];
        ca[j] = age_q[nxt];
      end else begin
        cv[j] = val_q[j];
        ca[j] = age_q[j];
      end
    end
    pos = CW'($countones(le));
    for (int i = 0; i < MAX_WINDOW; i++) begin
      prv = (i > 0) ? i - 1 : 0;
      if (CW'(i) < pos) begin
        vals_o[i] = cv[i];
        age_d[i]  = ca[i] + IW'(1);
      end else if (CW'(i) == pos) begin
        vals_o[i] = sample_i;
        age_d[i]  = '0;
      end else begin
        vals_o[i] = cv[prv];
        age_d[i]  = ca[prv] + IW'(1);
      end
    end
    fill_d = full ? fill_eff : fill_eff + CW'(1);
    emit_o = (fill_d == k_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (ctrl_i.flush) begin
      fill_q <= '0;
    end else if (ctrl_i.step) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      val_q <= vals_o;
      age_q <= age_d;
    end
  end

endmodule

// ===== hw/rtl/swm_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_median
// Pick the two middle cells of the sorted window and add them, giving the
// median with one fractional bit.
// ----------------------------------------------------------------------------
module swm_median #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  logic signed [SAMPLE_BITS-1:0]   vals_i [MAX_WINDOW],
  input  logic [$clog2(MAX_WINDOW+1)-1:0] k_i,
  output logic signed [SAMPLE_BITS:0]     median_x2_o
);
  import swm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [CW-1:0]                 lo_w, hi_w;
  logic [IW-1:0]                 lo_idx, hi_idx;
  logic signed [SAMPLE_BITS-1:0] lo_val, hi_val;

  always_comb begin
    lo_w        = (k_i - CW'(1)) >> 1;
    hi_w        = k_i >> 1;
    lo_idx      = lo_w[IW-1:0];
    hi_idx      = hi_w[IW-1:0];
    lo_val      = vals_i[lo_idx];
    hi_val      = vals_i[hi_idx];
    median_x2_o = {lo_val[SAMPLE_BITS-1], lo_val} + {hi_val[SAMPLE_BITS-1], hi_val};
  end

endmodule

// ===== hw/rtl/sliding_window_median.sv =====
`timescale 1ns / 1ps
// Result: the result of an item is registered at the edge at which the item leaves the
//   input register, where the item waits while a result is held by out_stall_i.
// Throughput: one item per cycle; the window update (a parallel compare over all cells)
//   is combinational between the input register and the result register.
//   The input stalls only while a result is held by out_stall_i and the waiting item gives one.
// Reset: asynchronous, active low; empties the window and sets the window size to 1.
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median filter over the last window_size signed samples.
// ----------------------------------------------------------------------------
module sliding_window_median #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [swm_pkg::CfgW-1:0]       cfg_window_size_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample_i,
  input  logic                           in_restart_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_BITS:0]    out_median_x2_o
);
  import swm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);

  logic                          in_vld_q, in_vld_d;
  logic signed [SAMPLE_BITS-1:0] in_sample_q;
  logic                          in_restart_q;
  logic [CW-1:0]                 k_q, k_d;
  logic                          out_vld_q, out_vld_d;
  logic signed [SAMPLE_BITS:0]   out_med_q;
  logic signed [SAMPLE_BITS-1:0] vals [MAX_WINDOW];
  logic signed [SAMPLE_BITS:0]   median;
  logic                          emit, out_free, adv, accept, cfg_wr;
  swm_ctrl_t                     ctrl;

  assign cfg_ready_o = !in_vld_q;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign adv         = in_vld_q && (!emit || out_free);
  assign in_stall_o  = in_vld_q && !adv;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_vld_d    = accept || (in_vld_q && !adv);

  always_comb begin
    if (cfg_window_size_i == '0) begin
      k_d = CW'(1);
    end else if (32'(cfg_window_size_i) > MAX_WINDOW) begin
      k_d = CW'(MAX_WINDOW);
    end else begin
      k_d = CW'(cfg_window_size_i);
    end
    ctrl.step    = adv;
    ctrl.restart = in_restart_q;
    ctrl.flush   = cfg_wr;
    if (adv && emit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  swm_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .k_i     (k_q),
    .sample_i(in_sample_q),
    .vals_o  (vals),
    .emit_o  (emit)
  );

  swm_median #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_median (
    .vals_i     (vals),
    .k_i        (k_q),
    .median_x2_o(median)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      k_q       <= CW'(1);
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_wr) begin
        k_q <= k_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_sample_q  <= in_sample_i;
      in_restart_q <= in_restart_i;
    end
    if (adv && emit) begin
      out_med_q <= median;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_median_x2_o = out_med_q;

endmodule

// ===== hw/rtl/swm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks of the median filter handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker #(
  parameter int SAMPLE_BITS = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS:0]   out_median_x2_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_median_x2_o))
    else $error("stalled result item changed or dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result item without an item accepted two cycles earlier");

endmodule

bind sliding_window_median swm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swm_checker (.*);

// ===== test/tb_sliding_window_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median
// Drives signed samples through the running median filter with random gaps
// and output stalls. A predictor keeps its own sorted window and arrival ring
// and works out twice the median for every item once its window is full. Each
// window size is written only while the filter is idle.
// ----------------------------------------------------------------------------
module tb_sliding_window_median;

  localparam int SAMPLE_W   = 32;
  localparam int WIN_MAX    = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 500;
  localparam int CFG_W      = swm_pkg::CfgW;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOT = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [swm_pkg::CfgW-1:0]          cfg_window_size_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic signed [SAMPLE_W-1:0]        in_sample_i;
  logic                              in_restart_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [SAMPLE_W:0]          out_median_x2_o;

  bit steady;
  int idle_cycles;

  class median_predictor;
    logic signed [SAMPLE_W-1:0] sorted_q [WIN_MAX];
    logic signed [SAMPLE_W-1:0] ring [WIN_MAX];
    int unsigned oldest;
    int unsigned fill;
    int unsigned win;
    logic signed [SAMPLE_W:0] medians_due [$];
    int unsigned mismatches;

    function new();
      win = 1;
      oldest = 0;
      fill = 0;
      mismatches = 0;
    endfunction

    function void set_window(logic [swm_pkg::CfgW-1:0] v);
      win = (v == 0) ? 1 : ((v > WIN_MAX) ? WIN_MAX : v);
      oldest = 0;
      fill = 0;
    endfunction

    function void insert_sorted(int unsigned n, logic signed [SAMPLE_W-1:0] s);
      int unsigned i;
      i = n;
      while (i > 0 && s < sorted_q[i-1]) begin
        sorted_q[i] = sorted_q[i-1];
        i--;
      end
      sorted_q[i] = s;
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] s, logic restart);
      logic signed [SAMPLE_W:0] m;
      int unsigned j;
      if (restart) begin
        oldest = 0;
        fill = 0;
      end
      if (oldest >= win) oldest = 0;
      if (fill < win) begin
        ring[(oldest + fill) % win] = s;
        insert_sorted(fill, s);
        fill++;
        if (fill < win) return;
      end else begin
        // retire exactly one copy of the oldest sample
        j = 0;
        while (j + 1 < win && sorted_q[j] != ring[oldest]) j++;
        for (int unsigned i = j; i + 1 < win; i++) sorted_q[i] = sorted_q[i+1];
        insert_sorted(win - 1, s);
        ring[oldest] = s;
        oldest = (oldest + 1) % win;
      end
      if (win[0]) m = {sorted_q[win/2], 1'b0};
      else m = sorted_q[win/2 - 1] + sorted_q[win/2];
      medians_due.insert(medians_due.size(), m);
    endfunction

    function void check_median(logic signed [SAMPLE_W:0] got);
      logic signed [SAMPLE_W:0] want;
      if (medians_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected median_x2 %0d", got);
        return;
      end
      want = medians_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("median_x2 mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  median_predictor median_pred;

  sliding_window_median #(
    .MAX_WINDOW  (WIN_MAX),
    .SAMPLE_BITS (SAMPLE_W)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_window_size_i (cfg_window_size_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_sample_i       (in_sample_i),
    .in_restart_i      (in_restart_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_median_x2_o   (out_median_x2_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= steady ? 1'b0 : ($urandom_range(0, 99) < 34);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) median_pred.take_sample(in_sample_i, in_restart_i);
      if (out_valid_o && !out_stall_i) median_pred.check_median(out_median_x2_o);
      if (cfg_valid_i && cfg_ready_o) median_pred.set_window(cfg_window_size_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic restart);
    while (!steady && $urandom_range(0, 99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    in_sample_i  <= s;
    in_restart_i <= restart;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // hold the sender until every median has come, then let the pipeline empty
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    while (median_pred.medians_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [swm_pkg::CfgW-1:0] v);
    hold_until_drained();
    cfg_valid_i       <= 1'b1;
    cfg_window_size_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_TOP;
      1:       return SAMPLE_BOT;
      2, 3, 4: return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int sent;
    int phase_len;
    logic [swm_pkg::CfgW-1:0] size;
    median_pred = new();
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_window_size_i = '0;
    in_valid_i        = 1'b0;
    in_sample_i       = '0;
    in_restart_i      = 1'b0;
    out_stall_i       = 1'b0;
    steady            = 1'b0;
    idle_cycles       = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // window of one straight out of reset
    send_sample(SAMPLE_TOP, 1'b0);
    send_sample(SAMPLE_BOT, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(5, 1'b1);
    send_sample(1, 1'b0);

    // even window: largest and smallest sums
    write_window(CFG_W'(2));
    send_sample(SAMPLE_TOP, 1'b0);
    send_sample(SAMPLE_TOP, 1'b0);
    send_sample(SAMPLE_BOT, 1'b0);
    send_sample(SAMPLE_BOT, 1'b0);
    send_sample(SAMPLE_BOT, 1'b1);
    send_sample(SAMPLE_TOP, 1'b0);

    // equal copies: retire only the oldest one
    write_window(CFG_W'(3));
    send_sample(4, 1'b0);
    send_sample(4, 1'b0);
    send_sample(9, 1'b0);
    send_sample(4, 1'b0);
    send_sample(4, 1'b1);
    send_sample(9, 1'b0);

    write_window('0);
    send_sample(-7, 1'b0);
    send_sample(7, 1'b0);

    sent = 0;
    size = '1;
    while (sent < RAND_ITEMS) begin
      write_window(size);
      phase_len = $urandom_range(30, 80);
      for (int i = 0; i < phase_len; i++) begin
        steady = (sent >= 150 && sent < 250);
        if (i == phase_len / 2) hold_until_drained();
        send_sample(pick_sample(), $urandom_range(0, 99) < 4);
        sent++;
      end
      case ($urandom_range(0, 9))
        0:       size = '0;
        1:       size = CFG_W'(WIN_MAX);
        2:       size = CFG_W'($urandom_range(WIN_MAX + 1, 31));
        default: size = CFG_W'($urandom_range(1, WIN_MAX - 1));
      endcase
    end
    steady = 1'b0;

    hold_until_drained();
    if (median_pred.mismatches == 0 && median_pred.medians_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/swm_pkg.sv
hw/rtl/swm_window.sv
hw/rtl/swm_median.sv
hw/rtl/sliding_window_median.sv
hw/rtl/swm_checker.sv
test/tb_sliding_window_median.sv
